### design/cwm_pkg.sv
// Shared types and constants for the clipped window median filter.
`timescale 1ns / 1ps

package cwm_pkg;

    localparam int PIX_W          = 8;
    localparam int CFG_W          = 11;
    localparam int CFG_IDX_W      = 2;
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_MAX_WIN    = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_WIN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    localparam logic REQ_PIXEL = 1'b0;

    localparam logic [2:0]       RST_WIN = 3'd3;
    localparam logic [CFG_W-1:0] RST_DIM = 11'd1024;

    // contents of one sorting cell
    typedef struct packed {
        logic             vld;
        logic [PIX_W-1:0] val;
    } t_cell;

    // control broadcast to every cell
    typedef struct packed {
        logic             clr;
        logic             ins;
        logic             shift;
        logic [PIX_W-1:0] val;
    } t_cell_ctl;

endpackage

### design/clipped_window_median_filter.sv
// Top level of the clipped window median filter.
// Usage: pixels enter in raster order on the input channel (i_in_valid / o_in_stall,
// i_req_type 0 = pixel, 1 = flush tick). One median per pixel leaves in raster order
// on the output channel (o_out_valid / i_out_stall); o_end_of_image marks the last one.
// The window is clipped at the borders; an even pixel count gives the truncated mean
// of the two middle values. Flush beats drain results still pending after image end.
// The block takes one beat at a time. A beat that yields a result reads the N pixels
// of the clipped window (N up to 49) through the one read port of the line store,
// feeding the sorting chain one pixel a cycle, then shifts the chain out to its middle.
// A finished result sits in the output register; a stall there only holds the next
// result in its final state. Reset clears the row and column counters and restores
// window 3 and a 1024 x 1024 image; the line store is not cleared and needs no
// clearing pass.
// Configuration writes (i_cfg_we, i_cfg_idx, i_cfg_data) restart the frame.
`timescale 1ns / 1ps

module clipped_window_median_filter #(
    parameter int MAX_WIDTH  = cwm_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = cwm_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_WIN    = cwm_pkg::DEF_MAX_WIN
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [cwm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cwm_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_req_type,
    input  logic [cwm_pkg::PIX_W-1:0]      i_pixel,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [cwm_pkg::PIX_W-1:0]      o_median,
    output logic                           o_end_of_image
);

    localparam int RING  = MAX_WIN + 1;
    localparam int GW    = $clog2(RING);
    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int CW    = $clog2(MAX_WIDTH + 1);
    localparam int RW    = $clog2(MAX_HEIGHT + 1);
    localparam int XCW   = (CW > cwm_pkg::CFG_W) ? CW : cwm_pkg::CFG_W;
    localparam int XRW   = (RW > cwm_pkg::CFG_W) ? RW : cwm_pkg::CFG_W;
    localparam int DEPTH = RING << AW;
    localparam int MW    = $clog2(DEPTH);
    localparam int NCELL = MAX_WIN * MAX_WIN;
    localparam int NW    = $clog2(NCELL + 1);
    localparam int TOP   = (MAX_WIN % 2 == 1) ? MAX_WIN : MAX_WIN - 1;
    localparam int HW    = $clog2(TOP);
    localparam int PW    = cwm_pkg::PIX_W;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_CHK    = 6'b000010,
        S_GATHER = 6'b000100,
        S_TAIL   = 6'b001000,
        S_DRAIN  = 6'b010000,
        S_FIN    = 6'b100000
    } t_state;

    t_state r_state;
    logic [2:0]              r_cfg_win;
    logic [cwm_pkg::CFG_W-1:0] r_cfg_w, r_cfg_h;
    logic [RW-1:0] r_in_row, r_out_row, r_rr, r_r1;
    logic [CW-1:0] r_in_col, r_out_col, r_rc, r_c0, r_c1;
    logic [GW-1:0] r_in_ring, r_out_ring, r_rg;
    logic [PW-1:0] r_mem [DEPTH];
    logic [PW-1:0] r_rdata, r_lo, r_res, r_med;
    logic          r_rdv;
    logic [NW-1:0] r_n, r_k;
    logic          r_ov, r_eoi;

    // effective configuration
    logic [CW-1:0] w_w;
    logic [RW-1:0] w_h;
    logic [2:0]    w_win;
    logic [HW-1:0] w_half;

    always_comb begin
        if (r_cfg_w == '0) begin
            w_w = CW'(1);
        end else if (XCW'(r_cfg_w) > XCW'(MAX_WIDTH)) begin
            w_w = CW'(MAX_WIDTH);
        end else begin
            w_w = CW'(r_cfg_w);
        end
        if (r_cfg_h == '0) begin
            w_h = RW'(1);
        end else if (XRW'(r_cfg_h) > XRW'(MAX_HEIGHT)) begin
            w_h = RW'(MAX_HEIGHT);
        end else begin
            w_h = RW'(r_cfg_h);
        end
        w_win = r_cfg_win;
        if (!w_win[0]) begin
            w_win = (w_win == 3'd0) ? 3'd1 : w_win - 3'd1;
        end
        if (5'(w_win) > 5'(TOP)) begin
            w_win = 3'(TOP);
        end
        w_half = HW'(w_win >> 1);
    end

    logic w_in_acc, w_wr, w_out_take;
    assign w_in_acc   = i_in_valid && (r_state == S_IDLE);
    assign w_wr       = w_in_acc && (i_req_type == cwm_pkg::REQ_PIXEL)
                        && (r_in_row < w_h) && (r_in_col < w_w);
    assign w_out_take = r_ov && !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);

    // window bounds of the pending result
    logic [RW:0]   w_nr_s, w_r0_s;
    logic [CW:0]   w_nc_s, w_c0_s;
    logic [RW-1:0] w_nr, w_r0;
    logic [CW-1:0] w_nc, w_c0;
    logic [GW-1:0] w_dr, w_g0;
    logic          w_pend, w_ready, w_eoi;

    always_comb begin
        w_nr_s = (RW+1)'(r_out_row) + (RW+1)'(w_half);
        w_nc_s = (CW+1)'(r_out_col) + (CW+1)'(w_half);
        w_nr   = (w_nr_s > (RW+1)'(w_h - 1'b1)) ? w_h - 1'b1 : RW'(w_nr_s);
        w_nc   = (w_nc_s > (CW+1)'(w_w - 1'b1)) ? w_w - 1'b1 : CW'(w_nc_s);
        w_r0_s = (RW+1)'(r_out_row) - (RW+1)'(w_half);
        w_c0_s = (CW+1)'(r_out_col) - (CW+1)'(w_half);
        w_r0   = w_r0_s[RW] ? '0 : RW'(w_r0_s);
        w_c0   = w_c0_s[CW] ? '0 : CW'(w_c0_s);
        w_dr   = GW'(r_out_row - w_r0);
        // ring slot of the top window row
        w_g0   = (r_out_ring >= w_dr) ? r_out_ring - w_dr
                                      : GW'((GW+1)'(r_out_ring) + (GW+1)'(RING) - (GW+1)'(w_dr));
        w_pend  = (r_out_row < w_h) && (r_out_col < w_w);
        w_ready = (r_in_row > w_nr) || ((r_in_row == w_nr) && (r_in_col > w_nc));
        w_eoi   = (r_out_row == w_h - 1'b1) && (r_out_col == w_w - 1'b1);
    end

    // line store
    logic [MW-1:0] w_waddr, w_raddr;
    logic          w_rd;
    assign w_waddr = MW'({r_in_ring, r_in_col[AW-1:0]});
    assign w_raddr = MW'({r_rg, r_rc[AW-1:0]});
    assign w_rd    = (r_state == S_GATHER);

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[w_waddr] <= i_pixel;
        end
        if (w_rd) begin
            r_rdata <= r_mem[w_raddr];
        end
    end

    // sorting chain
    cwm_pkg::t_cell_ctl w_ctl;
    cwm_pkg::t_cell     w_head;
    logic [PW:0]        w_sum;

    assign w_ctl.clr   = (r_state == S_CHK);
    assign w_ctl.ins   = r_rdv;
    assign w_ctl.shift = (r_state == S_DRAIN);
    assign w_ctl.val   = r_rdata;
    assign w_sum       = (PW+1)'(r_lo) + (PW+1)'(w_head.val);

    cwm_sorter #(.NCELL(NCELL)) u_sorter (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (w_ctl),
        .o_head (w_head)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cfg_win  <= cwm_pkg::RST_WIN;
            r_cfg_w    <= cwm_pkg::RST_DIM;
            r_cfg_h    <= cwm_pkg::RST_DIM;
            r_in_row   <= '0;
            r_in_col   <= '0;
            r_in_ring  <= '0;
            r_out_row  <= '0;
            r_out_col  <= '0;
            r_out_ring <= '0;
            r_rdv      <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            r_rdv <= w_rd;
            if (w_out_take) begin
                r_ov <= 1'b0;
            end
            if (i_cfg_we && (i_cfg_idx == cwm_pkg::CFG_WIN || i_cfg_idx == cwm_pkg::CFG_WIDTH
                             || i_cfg_idx == cwm_pkg::CFG_HEIGHT)) begin
                case (i_cfg_idx)
                    cwm_pkg::CFG_WIN:   r_cfg_win <= i_cfg_data[2:0];
                    cwm_pkg::CFG_WIDTH: r_cfg_w   <= i_cfg_data;
                    default:            r_cfg_h   <= i_cfg_data;
                endcase
                r_in_row   <= '0;
                r_in_col   <= '0;
                r_in_ring  <= '0;
                r_out_row  <= '0;
                r_out_col  <= '0;
                r_out_ring <= '0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_wr) begin
                        if (r_in_col + 1'b1 >= w_w) begin
                            r_in_col  <= '0;
                            r_in_row  <= r_in_row + 1'b1;
                            r_in_ring <= (r_in_ring == GW'(RING - 1)) ? '0 : r_in_ring + 1'b1;
                        end else begin
                            r_in_col <= r_in_col + 1'b1;
                        end
                    end
                    if (w_in_acc) begin
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (w_pend && w_ready) begin
                        r_rr    <= w_r0;
                        r_r1    <= w_nr;
                        r_rc    <= w_c0;
                        r_c0    <= w_c0;
                        r_c1    <= w_nc;
                        r_rg    <= w_g0;
                        r_state <= S_GATHER;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_GATHER: begin
                    if (r_rc == r_c1) begin
                        r_rc <= r_c0;
                        r_rr <= r_rr + 1'b1;
                        r_rg <= (r_rg == GW'(RING - 1)) ? '0 : r_rg + 1'b1;
                        if (r_rr == r_r1) begin
                            r_state <= S_TAIL;
                        end
                    end else begin
                        r_rc <= r_rc + 1'b1;
                    end
                end
                S_TAIL: begin
                    r_state <= S_DRAIN;
                end
                S_DRAIN: begin
                    if (r_k == (r_n >> 1) - 1'b1) begin
                        r_lo <= w_head.val;
                    end
                    if (r_k == (r_n >> 1)) begin
                        r_res   <= r_n[0] ? w_head.val : w_sum[PW:1];
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    // hold until the output register is free
                    if (!r_ov || w_out_take) begin
                        r_ov    <= 1'b1;
                        r_med   <= r_res;
                        r_eoi   <= w_eoi;
                        r_state <= S_IDLE;
                        if (w_eoi) begin
                            r_in_row   <= '0;
                            r_in_col   <= '0;
                            r_in_ring  <= '0;
                            r_out_row  <= '0;
                            r_out_col  <= '0;
                            r_out_ring <= '0;
                        end else if (r_out_col + 1'b1 >= w_w) begin
                            r_out_col  <= '0;
                            r_out_row  <= r_out_row + 1'b1;
                            r_out_ring <= (r_out_ring == GW'(RING - 1)) ? '0
                                                                        : r_out_ring + 1'b1;
                        end else begin
                            r_out_col <= r_out_col + 1'b1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // pixel count of the window
    always_ff @(posedge i_clk) begin
        if (r_state == S_CHK) begin
            r_n <= '0;
            r_k <= '0;
        end else if (r_rdv) begin
            r_n <= r_n + 1'b1;
        end
        if (r_state == S_DRAIN) begin
            r_k <= r_k + 1'b1;
        end
    end

    assign o_out_valid    = r_ov;
    assign o_median       = r_med;
    assign o_end_of_image = r_eoi;

    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n) $onehot(r_state))
        else $error("state not one-hot");
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> $past(r_state == S_FIN))
        else $error("result loaded outside final state");
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> (r_k <= r_n) && (r_n != '0))
        else $error("drain past window count");
    a_ins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rdv |-> (r_state == S_GATHER || r_state == S_TAIL))
        else $error("insert outside gather");

endmodule

### design/cwm_cell.sv
// One cell of the insertion sorting chain.
`timescale 1ns / 1ps

module cwm_cell #(
    parameter bit FIRST = 1'b0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cwm_pkg::t_cell_ctl i_ctl,
    input  cwm_pkg::t_cell    i_prev,
    input  cwm_pkg::t_cell    i_next,
    output cwm_pkg::t_cell    o_cell
);

    cwm_pkg::t_cell r_cell;
    cwm_pkg::t_cell n_cell;
    logic           w_keep;
    logic           w_take;

    always_comb begin
        w_keep = r_cell.vld && (r_cell.val <= i_ctl.val);
        w_take = FIRST || (i_prev.vld && (i_prev.val <= i_ctl.val));
        n_cell = r_cell;
        if (i_ctl.clr) begin
            n_cell.vld = 1'b0;
        end else if (i_ctl.shift) begin
            n_cell = i_next;
        end else if (i_ctl.ins && !w_keep) begin
            // larger values move one cell up, the new value lands at the boundary
            if (w_take) begin
                n_cell.vld = 1'b1;
                n_cell.val = i_ctl.val;
            end else begin
                n_cell = i_prev;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.vld <= 1'b0;
        end else begin
            r_cell.vld <= n_cell.vld;
        end
        r_cell.val <= n_cell.val;
    end

    assign o_cell = r_cell;

endmodule

### design/cwm_sorter.sv
// Chain of sorting cells; head of the chain is the smallest value.
`timescale 1ns / 1ps

module cwm_sorter #(
    parameter int NCELL = 49
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cwm_pkg::t_cell_ctl i_ctl,
    output cwm_pkg::t_cell     o_head
);

    cwm_pkg::t_cell w_cell [NCELL];

    for (genvar i = 0; i < NCELL; i++) begin : g_cell
        cwm_pkg::t_cell w_prev;
        cwm_pkg::t_cell w_next;
        if (i == 0) begin : g_first
            assign w_prev = '0;
        end else begin : g_prev
            assign w_prev = w_cell[i-1];
        end
        if (i == NCELL - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_nxt
            assign w_next = w_cell[i+1];
        end
        cwm_cell #(.FIRST(i == 0)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctl  (i_ctl),
            .i_prev (w_prev),
            .i_next (w_next),
            .o_cell (w_cell[i])
        );
    end

    assign o_head = w_cell[0];

endmodule

### tb/cwm_checker.sv
// Checker for the clipped window median filter: predicts each median beat and compares.
`timescale 1ns / 1ps

module cwm_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [cwm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [cwm_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic                          i_req_type,
    input  logic [cwm_pkg::PIX_W-1:0]     i_pixel,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic [cwm_pkg::PIX_W-1:0]     i_median,
    input  logic                          i_end_of_image,
    output int                            o_errors,
    output int                            o_pending,
    output logic                          o_frame_idle
);

    localparam int LINE_LEN = cwm_pkg::DEF_MAX_WIDTH;
    localparam int RING     = cwm_pkg::DEF_MAX_WIN + 1;
    localparam int NVAL     = cwm_pkg::DEF_MAX_WIN * cwm_pkg::DEF_MAX_WIN;

    typedef struct packed {
        logic [cwm_pkg::PIX_W-1:0] median;
        logic                      eoi;
    } t_median_beat;

    logic [cwm_pkg::PIX_W-1:0] line_ring [0:RING*LINE_LEN-1];
    t_median_beat              medians_due [$];
    logic [2:0]                win_reg;
    logic [cwm_pkg::CFG_W-1:0] width_reg, height_reg;
    int                        row_in, col_in, row_out, col_out;

    function automatic int clamp_dim(int v, int top);
        if (v < 1) return 1;
        if (v > top) return top;
        return v;
    endfunction

    function automatic int win_side(logic [2:0] v);
        int s;
        s = v;
        if (s % 2 == 0) s = (s == 0) ? 1 : s - 1;
        if (s > cwm_pkg::DEF_MAX_WIN) s = cwm_pkg::DEF_MAX_WIN;
        return s;
    endfunction

    always @(posedge i_clk) begin : predict
        int                        w, ht, hf, nr, nc, r0, c0, n, k, med, nerr;
        logic [cwm_pkg::PIX_W-1:0] v;
        logic [cwm_pkg::PIX_W-1:0] vals [0:NVAL-1];
        t_median_beat              got, exp_beat;
        if (!i_rst_n) begin
            medians_due.delete();
            win_reg    = cwm_pkg::RST_WIN;
            width_reg  = cwm_pkg::RST_DIM;
            height_reg = cwm_pkg::RST_DIM;
            row_in = 0; col_in = 0; row_out = 0; col_out = 0;
            o_errors <= 0;
        end else begin
            nerr = 0;
            if (i_out_valid && !i_out_stall) begin
                got.median = i_median;
                got.eoi    = i_end_of_image;
                if (medians_due.size() == 0) begin
                    $error("median beat with nothing due: median %0d eoi %0d",
                           got.median, got.eoi);
                    nerr++;
                end else begin
                    exp_beat = medians_due.pop_front();
                    if (got.median !== exp_beat.median) begin
                        $error("median: expected %0d, got %0d", exp_beat.median, got.median);
                        nerr++;
                    end
                    if (got.eoi !== exp_beat.eoi) begin
                        $error("end_of_image: expected %0d, got %0d", exp_beat.eoi, got.eoi);
                        nerr++;
                    end
                end
            end
            if (i_cfg_we && (i_cfg_idx == cwm_pkg::CFG_WIN || i_cfg_idx == cwm_pkg::CFG_WIDTH
                             || i_cfg_idx == cwm_pkg::CFG_HEIGHT)) begin
                case (i_cfg_idx)
                    cwm_pkg::CFG_WIN:    win_reg    = i_cfg_data[2:0];
                    cwm_pkg::CFG_WIDTH:  width_reg  = i_cfg_data;
                    cwm_pkg::CFG_HEIGHT: height_reg = i_cfg_data;
                    default: ;
                endcase
                row_in = 0; col_in = 0; row_out = 0; col_out = 0;
            end
            if (i_in_valid && !i_in_stall) begin
                w  = clamp_dim(width_reg, cwm_pkg::DEF_MAX_WIDTH);
                ht = clamp_dim(height_reg, cwm_pkg::DEF_MAX_HEIGHT);
                hf = win_side(win_reg) / 2;
                if (i_req_type == cwm_pkg::REQ_PIXEL && row_in < ht && col_in < w) begin
                    line_ring[(row_in % RING) * LINE_LEN + col_in] = i_pixel;
                    col_in++;
                    if (col_in >= w) begin
                        col_in = 0;
                        row_in++;
                    end
                end
                if (row_out < ht && col_out < w) begin
                    nr = (row_out + hf > ht - 1) ? ht - 1 : row_out + hf;
                    nc = (col_out + hf > w - 1) ? w - 1 : col_out + hf;
                    if (row_in > nr || (row_in == nr && col_in > nc)) begin
                        r0 = (row_out >= hf) ? row_out - hf : 0;
                        c0 = (col_out >= hf) ? col_out - hf : 0;
                        n = 0;
                        for (int r = r0; r <= nr; r++) begin
                            for (int c = c0; c <= nc; c++) begin
                                v = line_ring[(r % RING) * LINE_LEN + c];
                                k = n;
                                while (k > 0 && vals[k-1] > v) begin
                                    vals[k] = vals[k-1];
                                    k--;
                                end
                                vals[k] = v;
                                n++;
                            end
                        end
                        if (n % 2 == 1) med = vals[n/2];
                        else med = (int'(vals[n/2]) + int'(vals[n/2-1])) / 2;
                        exp_beat.median = med[cwm_pkg::PIX_W-1:0];
                        exp_beat.eoi    = (row_out == ht - 1) && (col_out == w - 1);
                        medians_due.insert(medians_due.size(), exp_beat);
                        col_out++;
                        if (col_out >= w) begin
                            col_out = 0;
                            row_out++;
                        end
                        if (exp_beat.eoi) begin
                            row_in = 0; col_in = 0; row_out = 0; col_out = 0;
                        end
                    end
                end
            end
            o_errors <= o_errors + nerr;
        end
        o_pending    <= medians_due.size();
        o_frame_idle <= (row_in == 0 && col_in == 0 && row_out == 0 && col_out == 0);
    end

endmodule

### tb/clipped_window_median_filter_tb.sv
// Stimulus and verdict for the clipped window median filter testbench.
`timescale 1ns / 1ps

module clipped_window_median_filter_tb;

    localparam int  IDLE_LIMIT  = 5000;
    localparam int  TARGET_BEATS = 1550;
    localparam logic REQ_FLUSH = 1'b1;
    localparam logic [cwm_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_we = 1'b0;
    logic [cwm_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [cwm_pkg::CFG_W-1:0]     i_cfg_data = '0;
    logic                          i_in_valid = 1'b0;
    logic                          i_req_type = cwm_pkg::REQ_PIXEL;
    logic [cwm_pkg::PIX_W-1:0]     i_pixel = '0;
    logic                          i_out_stall = 1'b0;
    logic                          o_in_stall, o_out_valid, o_end_of_image;
    logic [cwm_pkg::PIX_W-1:0]     o_median;
    int                            errors, pending;
    logic                          frame_idle;

    bit quiet = 0;
    bit hold_req = 0;
    bit hold_done = 0;
    int beats_sent = 0;
    int idle_cycles = 0;

    clipped_window_median_filter u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_req_type(i_req_type), .i_pixel(i_pixel),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_median(o_median), .o_end_of_image(o_end_of_image)
    );

    cwm_checker u_check (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .i_in_stall(o_in_stall),
        .i_req_type(i_req_type), .i_pixel(i_pixel),
        .i_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .i_median(o_median), .i_end_of_image(o_end_of_image),
        .o_errors(errors), .o_pending(pending), .o_frame_idle(frame_idle)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // receiver: random stall bursts, one long hold-off, none when quiet
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                hold_done = 1;
                i_out_stall <= 1'b1;
                repeat (600) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else begin
                repeat ($urandom_range(1, 30)) @(posedge i_clk);
            end
        end
    end

    function automatic int clamp_dim(int v);
        if (v < 1) return 1;
        if (v > cwm_pkg::DEF_MAX_WIDTH) return cwm_pkg::DEF_MAX_WIDTH;
        return v;
    endfunction

    function automatic logic [cwm_pkg::PIX_W-1:0] pick_pixel();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            1: return 8'h80 + 8'($urandom_range(0, 3));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_beat(input logic kind, input logic [cwm_pkg::PIX_W-1:0] pix);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= kind;
        i_pixel    <= pix;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        beats_sent++;
    endtask

    task automatic write_reg(input logic [cwm_pkg::CFG_IDX_W-1:0] idx, input int data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data[cwm_pkg::CFG_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // wait until every due median has left, then let the block go quiet
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic set_frame(input int win, input int w, input int h);
        write_reg(cwm_pkg::CFG_WIN, win);
        write_reg(cwm_pkg::CFG_WIDTH, w);
        write_reg(cwm_pkg::CFG_HEIGHT, h);
    endtask

    // one image: pixels with stray flush beats, then, unless cut short, drain beats until the frame closes
    task automatic send_image(input int w, input int h, input int cut);
        int total;
        total = clamp_dim(w) * clamp_dim(h);
        if (cut > 0 && cut < total) total = cut;
        for (int i = 0; i < total; i++) begin
            if ($urandom_range(0, 11) == 0) send_beat(REQ_FLUSH, 8'($urandom_range(0, 255)));
            send_beat(cwm_pkg::REQ_PIXEL, pick_pixel());
        end
        i_in_valid <= 1'b0;
        if (cut > 0) return;
        forever begin
            @(posedge i_clk);
            if (frame_idle) break;
            send_beat($urandom_range(0, 1) ? REQ_FLUSH : cwm_pkg::REQ_PIXEL,
                      8'($urandom_range(0, 255)));
            i_in_valid <= 1'b0;
        end
    endtask

    initial begin
        int win, w, h, imgs;
        bit big;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset frame is huge: a few pixels only, then abandon it
        send_image(cwm_pkg::DEF_MAX_WIDTH, cwm_pkg::DEF_MAX_HEIGHT, 20);
        settle();
        write_reg(CFG_UNUSED, 11'h7FF);

        // single pixel images back to back, then small frames
        set_frame(1, 1, 1);
        send_beat(REQ_FLUSH, 8'hFF);
        send_image(1, 1, 0);
        send_image(1, 1, 0);
        settle();
        set_frame(7, 3, 3);
        send_image(3, 3, 0);
        settle();
        set_frame(2, 2, 3);
        send_image(2, 3, 0);
        settle();

        // widest and tallest frames, through saturation and zero
        set_frame(7, 11'h7FF, 0);
        send_image(cwm_pkg::DEF_MAX_WIDTH, 1, 40);
        settle();
        set_frame(6, 0, cwm_pkg::DEF_MAX_HEIGHT);
        send_image(1, cwm_pkg::DEF_MAX_HEIGHT, 40);
        settle();

        while (beats_sent < TARGET_BEATS) begin
            win = $urandom_range(0, 7);
            w = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 24) : $urandom_range(0, 12);
            h = $urandom_range(0, 10);
            big = 0;
            // long hold-off on a full size image so the block backs up
            if (beats_sent > 600 && !hold_done && !hold_req) begin
                hold_req = 1;
                big = 1;
                w = 24;
                h = 10;
            end
            set_frame(win, w, h);
            if (beats_sent > TARGET_BEATS - 250) quiet = 1;
            if (!big && $urandom_range(0, 9) == 0) begin
                send_image(w, h, $urandom_range(1, clamp_dim(w) * clamp_dim(h)));
            end else begin
                imgs = (big || beats_sent > TARGET_BEATS - 300) ? 1 : $urandom_range(1, 3);
                repeat (imgs) send_image(w, h, 0);
            end
            settle();
        end

        if (errors == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
